/* hw/rtl/vbps_pkg.sv */
// Shared types and constants for the ventilator breath phase sequencer.
package vbps_pkg;

	// Breath phase codes as they appear in the result beat.
	typedef enum logic [1:0] {
		PH_INHALE = 2'd0,
		PH_PAUSE  = 2'd1,
		PH_EXHALE = 2'd2
	} phase_t;

	// Kind of driver applied to the ventilator node.
	typedef enum logic [1:0] {
		DRV_NONE     = 2'd0,
		DRV_PRESSURE = 2'd1,
		DRV_FLOW     = 2'd2
	} drv_kind_t;

	// Register indexes on the configuration port (byte address is 4 times the index).
	localparam logic [2:0] REG_MODE_BITS     = 3'd0;
	localparam logic [2:0] REG_CYCLE_LIMIT   = 3'd1;
	localparam logic [2:0] REG_INHALE_DRIVE  = 3'd2;
	localparam logic [2:0] REG_PAUSE_TICKS   = 3'd3;
	localparam logic [2:0] REG_TRIGGER_TICKS = 3'd4;
	localparam logic [2:0] REG_TRIGGER_PRESS = 3'd5;
	localparam logic [2:0] REG_PEEP          = 3'd6;

	// Bit positions inside mode_bits.
	localparam int MODE_CYCLE_VOLUME  = 0;
	localparam int MODE_INHALE_FLOW   = 1;
	localparam int MODE_MACHINE_TRIG  = 2;
	localparam int MODE_PATIENT_TRIG  = 3;

	localparam logic [3:0] MODE_BITS_RESET = 4'd4;

	// One input tick.
	typedef struct packed {
		logic               connected;
		logic signed [15:0] volume_delta;
		logic signed [15:0] ventilator_pressure;
		logic signed [15:0] connection_pressure;
		logic signed [15:0] ambient_pressure;
	} tick_beat_t;

	// One result per tick.
	typedef struct packed {
		logic               active;
		logic               drive_is_flow;
		logic signed [15:0] drive_level;
		logic [1:0]         breath_phase;
		logic               no_trigger_error;
	} result_beat_t;

	// Configuration register contents as seen by the datapath.
	typedef struct packed {
		logic [3:0]         mode_bits;
		logic [23:0]        cycle_limit;
		logic signed [15:0] inhale_drive_value;
		logic [15:0]        pause_ticks;
		logic [15:0]        trigger_ticks;
		logic signed [15:0] trigger_pressure;
		logic signed [15:0] end_expiratory_pressure;
	} cfg_t;

endpackage

/* hw/rtl/ventilator_breath_phase_sequencer_top.sv */
// Top level of the ventilator breath phase sequencer.
//
// Each tick beat on the tick channel carries the connection flag, the
// Y-piece volume for the tick and three node pressures. For every tick the
// block returns one result beat on the result channel: whether a driver is
// applied, its kind and level, the breath phase after the tick and the
// missing-trigger error flag.
// A tick is registered in an input stage, evaluated by one pass of compare
// and add logic there, and its result is registered in the output stage once
// that stage is free. One tick is accepted every cycle while the result
// receiver does not stall; the single pass through the phase logic between
// the two registers sets that rate.
// When the result receiver stalls, the waiting result holds and the input
// stage still takes one more tick; only when both stages are full is the
// tick channel stalled.
// Reset puts the breath in exhale with zero period count and volume, no driver set, and all
// registers at their defaults (mode_bits = 4). The user writes registers over the APB-style
// port only while no ticks are in flight; the block itself does no check on this.
module ventilator_breath_phase_sequencer_top #(
	parameter int PERIOD_WIDTH = 16,
	parameter int VOLUME_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick_valid,
	output logic                   tick_stall,
	input  vbps_pkg::tick_beat_t   tick,
	output logic                   result_valid,
	input  logic                   result_stall,
	output vbps_pkg::result_beat_t result,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [4:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	vbps_pkg::cfg_t         cfg;
	vbps_pkg::tick_beat_t   tick_s1;
	logic                   tick_valid_s1;
	vbps_pkg::result_beat_t core_result;
	vbps_pkg::result_beat_t result_q;
	logic                   result_valid_q;
	logic                   out_free;
	logic                   step;

	vbps_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Flow control between the input stage and the result register.
	assign out_free   = !result_valid_q || !result_stall;
	assign step       = tick_valid_s1 && out_free;
	assign tick_stall = tick_valid_s1 && !out_free;

	vbps_phase_core #(
		.PERIOD_WIDTH (PERIOD_WIDTH),
		.VOLUME_WIDTH (VOLUME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.beat   (tick_s1),
		.cfg    (cfg),
		.result (core_result)
	);

	// Input stage valid and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1  <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (!tick_stall) begin
				tick_valid_s1 <= tick_valid;
			end
			if (out_free) begin
				result_valid_q <= tick_valid_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1 <= tick;
		end
		if (step) begin
			result_q <= core_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The tick channel stalls only when both stages hold beats and the output is held.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> tick_valid_s1 && result_valid_q && result_stall)
		else $error("tick channel stalled while a stage was free");

	// A disconnected tick yields an inactive result in exhale.
	a_disconnect_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && !tick_s1.connected |=>
			result_valid && !result.active && !result.no_trigger_error &&
			result.breath_phase == vbps_pkg::PH_EXHALE)
		else $error("disconnected tick gave a wrong result");

	// The error flag needs exhale and both triggers disabled.
	a_error_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.no_trigger_error |->
			result.breath_phase == vbps_pkg::PH_EXHALE &&
			!cfg.mode_bits[vbps_pkg::MODE_MACHINE_TRIG] &&
			!cfg.mode_bits[vbps_pkg::MODE_PATIENT_TRIG])
		else $error("no-trigger error flagged with a trigger enabled");

	// A result beat that is taken is followed by the next only if one was waiting.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !tick_valid_s1 |=> !result_valid)
		else $error("result beat appeared without a tick");

endmodule

/* hw/rtl/vbps_cfg_regs.sv */
// APB-style configuration register file for the breath phase sequencer.
module vbps_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	output vbps_pkg::cfg_t cfg
);

	logic [2:0] reg_index;
	logic       wr_en;

	assign pready    = 1'b1;
	assign reg_index = paddr[4:2];
	assign wr_en     = psel & penable & pwrite & pready;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.mode_bits               <= vbps_pkg::MODE_BITS_RESET;
			cfg.cycle_limit             <= '0;
			cfg.inhale_drive_value      <= '0;
			cfg.pause_ticks             <= '0;
			cfg.trigger_ticks           <= '0;
			cfg.trigger_pressure        <= '0;
			cfg.end_expiratory_pressure <= '0;
		end else if (wr_en) begin
			case (reg_index)
				vbps_pkg::REG_MODE_BITS:     cfg.mode_bits               <= pwdata[3:0];
				vbps_pkg::REG_CYCLE_LIMIT:   cfg.cycle_limit             <= pwdata[23:0];
				vbps_pkg::REG_INHALE_DRIVE:  cfg.inhale_drive_value      <= pwdata[15:0];
				vbps_pkg::REG_PAUSE_TICKS:   cfg.pause_ticks             <= pwdata[15:0];
				vbps_pkg::REG_TRIGGER_TICKS: cfg.trigger_ticks           <= pwdata[15:0];
				vbps_pkg::REG_TRIGGER_PRESS: cfg.trigger_pressure        <= pwdata[15:0];
				vbps_pkg::REG_PEEP:          cfg.end_expiratory_pressure <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back; signed registers come back sign-extended.
	always_comb begin
		case (reg_index)
			vbps_pkg::REG_MODE_BITS:     prdata = 32'(cfg.mode_bits);
			vbps_pkg::REG_CYCLE_LIMIT:   prdata = 32'(cfg.cycle_limit);
			vbps_pkg::REG_INHALE_DRIVE:  prdata = 32'(cfg.inhale_drive_value);
			vbps_pkg::REG_PAUSE_TICKS:   prdata = 32'(cfg.pause_ticks);
			vbps_pkg::REG_TRIGGER_TICKS: prdata = 32'(cfg.trigger_ticks);
			vbps_pkg::REG_TRIGGER_PRESS: prdata = 32'(cfg.trigger_pressure);
			vbps_pkg::REG_PEEP:          prdata = 32'(cfg.end_expiratory_pressure);
			default:                     prdata = '0;
		endcase
	end

endmodule

/* hw/rtl/vbps_phase_core.sv */
// Breath phase state and the single-tick next-state and result logic.
module vbps_phase_core #(
	parameter int PERIOD_WIDTH = 16,
	parameter int VOLUME_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  vbps_pkg::tick_beat_t   beat,
	input  vbps_pkg::cfg_t         cfg,
	output vbps_pkg::result_beat_t result
);

	localparam int LimW = (PERIOD_WIDTH > 24) ? PERIOD_WIDTH : 24;
	localparam int TckW = (PERIOD_WIDTH > 16) ? PERIOD_WIDTH : 16;

	// Architectural state.
	vbps_pkg::phase_t               phase_q;
	logic [PERIOD_WIDTH-1:0]        period_q;
	logic signed [VOLUME_WIDTH-1:0] volume_q;
	vbps_pkg::drv_kind_t            kind_q;
	logic signed [15:0]             level_q;

	// Next-state values built up phase by phase.
	vbps_pkg::phase_t               ph;
	logic [PERIOD_WIDTH-1:0]        pc;
	logic signed [VOLUME_WIDTH-1:0] vol;
	vbps_pkg::drv_kind_t            kind;
	logic signed [15:0]             lvl;
	logic                           armed;
	logic                           err;

	logic signed [VOLUME_WIDTH:0]   vol_sum;
	logic signed [VOLUME_WIDTH-1:0] vol_sat;
	logic                           vol_reached;
	logic                           time_reached;
	logic signed [17:0]             rel_press;

	// Saturating volume accumulation and the inhale end tests.
	assign vol_sum = (VOLUME_WIDTH+1)'(volume_q) + (VOLUME_WIDTH+1)'(beat.volume_delta);

	always_comb begin
		if (vol_sum[VOLUME_WIDTH] != vol_sum[VOLUME_WIDTH-1]) begin
			vol_sat = vol_sum[VOLUME_WIDTH] ? {1'b1, {(VOLUME_WIDTH-1){1'b0}}}
			                                : {1'b0, {(VOLUME_WIDTH-1){1'b1}}};
		end else begin
			vol_sat = vol_sum[VOLUME_WIDTH-1:0];
		end
	end

	assign vol_reached = (VOLUME_WIDTH+1)'(vol_sat) >=
		$signed({{(VOLUME_WIDTH-23){1'b0}}, cfg.cycle_limit});
	assign time_reached = LimW'(period_q) >= LimW'(cfg.cycle_limit);

	// Patient trigger pressure relative to ambient minus PEEP.
	assign rel_press = 18'(beat.connection_pressure) - 18'(beat.ambient_pressure)
		- 18'(cfg.end_expiratory_pressure);

	// Phases are evaluated inhale, pause, exhale so transitions cascade.
	always_comb begin
		ph    = phase_q;
		pc    = period_q;
		vol   = volume_q;
		kind  = kind_q;
		lvl   = level_q;
		armed = 1'b0;
		err   = 1'b0;

		if (!beat.connected) begin
			ph  = vbps_pkg::PH_EXHALE;
			pc  = '0;
			vol = '0;
		end else begin
			// Inhale: cycle on volume or on time.
			if (ph != vbps_pkg::PH_INHALE) begin
				vol = '0;
			end else begin
				vol = vol_sat;
				if (cfg.mode_bits[vbps_pkg::MODE_CYCLE_VOLUME] ? vol_reached : time_reached) begin
					if (cfg.mode_bits[vbps_pkg::MODE_CYCLE_VOLUME]) begin
						vol = '0;
					end
					ph = vbps_pkg::PH_PAUSE;
					pc = '0;
				end else begin
					kind = cfg.mode_bits[vbps_pkg::MODE_INHALE_FLOW] ? vbps_pkg::DRV_FLOW
					                                                 : vbps_pkg::DRV_PRESSURE;
					lvl  = cfg.inhale_drive_value;
				end
			end

			// Pause: hold the measured ventilator pressure.
			if (ph == vbps_pkg::PH_PAUSE) begin
				if (cfg.pause_ticks != '0 && TckW'(pc) < TckW'(cfg.pause_ticks)) begin
					kind = vbps_pkg::DRV_PRESSURE;
					lvl  = beat.ventilator_pressure;
				end else begin
					ph = vbps_pkg::PH_EXHALE;
					pc = '0;
				end
			end

			// Exhale: drive PEEP until a machine or patient trigger fires.
			if (ph == vbps_pkg::PH_EXHALE) begin
				if (cfg.mode_bits[vbps_pkg::MODE_MACHINE_TRIG] &&
				    TckW'(pc) >= TckW'(cfg.trigger_ticks)) begin
					ph = vbps_pkg::PH_INHALE;
					pc = '0;
				end else if (cfg.mode_bits[vbps_pkg::MODE_PATIENT_TRIG] &&
				             rel_press <= 18'(cfg.trigger_pressure)) begin
					ph = vbps_pkg::PH_INHALE;
					pc = '0;
				end else begin
					armed = cfg.mode_bits[vbps_pkg::MODE_MACHINE_TRIG] |
					        cfg.mode_bits[vbps_pkg::MODE_PATIENT_TRIG];
					kind  = vbps_pkg::DRV_PRESSURE;
					lvl   = cfg.end_expiratory_pressure;
					err   = !armed;
				end
			end

			// A driver that was never set applies zero pressure.
			if (kind == vbps_pkg::DRV_NONE) begin
				kind = vbps_pkg::DRV_PRESSURE;
				lvl  = '0;
			end

			// Period counter saturates at all ones.
			if (pc != {PERIOD_WIDTH{1'b1}}) begin
				pc = pc + 1'b1;
			end
		end
	end

	// Result fields for this tick.
	always_comb begin
		result.active           = beat.connected;
		result.drive_is_flow    = beat.connected && (kind == vbps_pkg::DRV_FLOW);
		result.drive_level      = beat.connected ? lvl : 16'sd0;
		result.breath_phase     = ph;
		result.no_trigger_error = beat.connected && err;
	end

	// State advances once per tick that leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= vbps_pkg::PH_EXHALE;
			period_q <= '0;
			volume_q <= '0;
			kind_q   <= vbps_pkg::DRV_NONE;
			level_q  <= '0;
		end else if (step) begin
			phase_q  <= ph;
			period_q <= pc;
			volume_q <= vol;
			kind_q   <= kind;
			level_q  <= lvl;
		end
	end

endmodule

/* bench/ventilator_breath_phase_sequencer_top_tb.sv */
// Self-checking testbench for the ventilator breath phase sequencer top level.
`timescale 1ns / 1ps

module ventilator_breath_phase_sequencer_top_tb;

	localparam int unsigned PERIOD_MAX = 32'hFFFF;
	localparam longint VOL_MAX = 64'sd2147483647;
	localparam longint VOL_MIN = -64'sd2147483648;

	// Tracks the breath state for every accepted tick and holds the results still due.
	class breath_scoreboard;
		vbps_pkg::result_beat_t results_due[$];
		int unsigned fails;

		logic [3:0] mode_bits;
		int unsigned cycle_limit;
		int inhale_drive;
		int unsigned pause_ticks;
		int unsigned trigger_ticks;
		int trigger_pressure;
		int peep;

		vbps_pkg::phase_t phase;
		int unsigned period;
		longint volume;
		vbps_pkg::drv_kind_t drv_kind;
		logic signed [15:0] drv_level;

		function new();
			fails = 0;
			mode_bits = vbps_pkg::MODE_BITS_RESET;
			cycle_limit = 0;
			inhale_drive = 0;
			pause_ticks = 0;
			trigger_ticks = 0;
			trigger_pressure = 0;
			peep = 0;
			phase = vbps_pkg::PH_EXHALE;
			period = 0;
			volume = 0;
			drv_kind = vbps_pkg::DRV_NONE;
			drv_level = '0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				vbps_pkg::REG_MODE_BITS:     mode_bits = val[3:0];
				vbps_pkg::REG_CYCLE_LIMIT:   cycle_limit = val[23:0];
				vbps_pkg::REG_INHALE_DRIVE:  inhale_drive = $signed(val[15:0]);
				vbps_pkg::REG_PAUSE_TICKS:   pause_ticks = val[15:0];
				vbps_pkg::REG_TRIGGER_TICKS: trigger_ticks = val[15:0];
				vbps_pkg::REG_TRIGGER_PRESS: trigger_pressure = $signed(val[15:0]);
				vbps_pkg::REG_PEEP:          peep = $signed(val[15:0]);
				default: ;
			endcase
		endfunction

		// Every phase change clears the period counter.
		function void advance_phase();
			period = 0;
			case (phase)
				vbps_pkg::PH_INHALE: phase = vbps_pkg::PH_PAUSE;
				vbps_pkg::PH_PAUSE:  phase = vbps_pkg::PH_EXHALE;
				default:             phase = vbps_pkg::PH_INHALE;
			endcase
		endfunction

		// Inhale accumulates volume and ends on time or volume; otherwise it drives.
		function void inhale_step(int dv);
			if (phase != vbps_pkg::PH_INHALE) begin
				volume = 0;
				return;
			end
			volume += dv;
			if (volume > VOL_MAX) volume = VOL_MAX;
			if (volume < VOL_MIN) volume = VOL_MIN;
			if (mode_bits[vbps_pkg::MODE_CYCLE_VOLUME]) begin
				if (volume >= longint'(cycle_limit)) begin
					volume = 0;
					advance_phase();
					return;
				end
			end else if (period >= cycle_limit) begin
				advance_phase();
				return;
			end
			drv_kind = mode_bits[vbps_pkg::MODE_INHALE_FLOW] ? vbps_pkg::DRV_FLOW
			                                                 : vbps_pkg::DRV_PRESSURE;
			drv_level = 16'(inhale_drive);
		endfunction

		// Pause holds the measured ventilator pressure while it lasts.
		function void pause_step(int vent_p);
			if (phase != vbps_pkg::PH_PAUSE)
				return;
			if (pause_ticks != 0 && period < pause_ticks) begin
				drv_kind = vbps_pkg::DRV_PRESSURE;
				drv_level = 16'(vent_p);
			end else begin
				advance_phase();
			end
		endfunction

		// Exhale drives PEEP; returns 1 when no trigger is enabled.
		function bit exhale_step(int conn_p, int amb_p);
			bit armed;
			int rel;
			armed = 1'b0;
			if (phase != vbps_pkg::PH_EXHALE)
				return 1'b0;
			if (mode_bits[vbps_pkg::MODE_MACHINE_TRIG]) begin
				if (period >= trigger_ticks) begin
					advance_phase();
					return 1'b0;
				end
				armed = 1'b1;
			end
			if (mode_bits[vbps_pkg::MODE_PATIENT_TRIG]) begin
				rel = conn_p - amb_p - peep;
				if (rel <= trigger_pressure) begin
					advance_phase();
					return 1'b0;
				end
				armed = 1'b1;
			end
			drv_kind = vbps_pkg::DRV_PRESSURE;
			drv_level = 16'(peep);
			return !armed;
		endfunction

		// Steps the breath by one accepted tick and queues its result.
		function void take_tick(vbps_pkg::tick_beat_t b);
			vbps_pkg::result_beat_t r;
			bit unarmed;
			r = '0;
			if (!b.connected) begin
				phase = vbps_pkg::PH_EXHALE;
				period = 0;
				volume = 0;
				r.breath_phase = vbps_pkg::PH_EXHALE;
			end else begin
				inhale_step(int'(b.volume_delta));
				pause_step(int'(b.ventilator_pressure));
				unarmed = exhale_step(int'(b.connection_pressure), int'(b.ambient_pressure));
				if (drv_kind == vbps_pkg::DRV_NONE) begin
					drv_kind = vbps_pkg::DRV_PRESSURE;
					drv_level = '0;
				end
				if (period < PERIOD_MAX) period++;
				r.active = 1'b1;
				r.drive_is_flow = (drv_kind == vbps_pkg::DRV_FLOW);
				r.drive_level = drv_level;
				r.breath_phase = phase;
				r.no_trigger_error = unarmed;
			end
			results_due.push_back(r);
		endfunction

		function void flag(string field, int want, int got);
			fails++;
			$error("%s: expected %0d, got %0d", field, want, got);
		endfunction

		function void check_result(vbps_pkg::result_beat_t got);
			vbps_pkg::result_beat_t want;
			if (results_due.size() == 0) begin
				fails++;
				$error("result beat arrived with no tick outstanding");
				return;
			end
			want = results_due.pop_front();
			if (got.active !== want.active)
				flag("active", want.active, got.active);
			if (got.drive_is_flow !== want.drive_is_flow)
				flag("drive_is_flow", want.drive_is_flow, got.drive_is_flow);
			if (got.drive_level !== want.drive_level)
				flag("drive_level", int'(want.drive_level), int'(got.drive_level));
			if (got.breath_phase !== want.breath_phase)
				flag("breath_phase", want.breath_phase, got.breath_phase);
			if (got.no_trigger_error !== want.no_trigger_error)
				flag("no_trigger_error", want.no_trigger_error, got.no_trigger_error);
		endfunction

		function int waiting();
			return results_due.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   tick_valid = 1'b0;
	logic                   tick_stall;
	vbps_pkg::tick_beat_t   tick = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	vbps_pkg::result_beat_t result;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [4:0]             paddr = '0;
	logic [31:0]            pwdata = '0;
	logic [31:0]            prdata;
	logic                   pready;

	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	breath_scoreboard sb = new();

	ventilator_breath_phase_sequencer_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick(tick),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#10_000_000;
		$display("ventilator_breath_phase_sequencer_top verification failed");
		$finish;
	end

	// Result receiver: checks each accepted beat, then stalls for a random count.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				sb.check_result(result);
				hold = rx_calm ? 0 : $urandom_range(0, 9);
			end else if (hold > 0) begin
				hold--;
			end
			result_stall <= (hold > 0);
		end
	end

	// One register write: setup, then access until pready, then back to idle.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic program_breath(input logic [3:0] mode, input logic [23:0] cyc,
			input logic [15:0] inh, input logic [15:0] pause_len,
			input logic [15:0] trig_len, input logic [15:0] trig_p, input logic [15:0] peep);
		write_reg(vbps_pkg::REG_MODE_BITS, 32'(mode));
		write_reg(vbps_pkg::REG_CYCLE_LIMIT, 32'(cyc));
		write_reg(vbps_pkg::REG_INHALE_DRIVE, 32'(inh));
		write_reg(vbps_pkg::REG_PAUSE_TICKS, 32'(pause_len));
		write_reg(vbps_pkg::REG_TRIGGER_TICKS, 32'(trig_len));
		write_reg(vbps_pkg::REG_TRIGGER_PRESS, 32'(trig_p));
		write_reg(vbps_pkg::REG_PEEP, 32'(peep));
	endtask

	// Random breath settings, mostly short so that phases turn over often.
	task automatic program_random();
		logic [3:0] mode;
		logic [23:0] cyc;
		logic [15:0] pause_len, trig_len, trig_p, peep;
		mode = 4'($urandom_range(0, 15));
		if (mode[3:2] == 2'b00 && $urandom_range(0, 3) != 0)
			mode[vbps_pkg::MODE_MACHINE_TRIG] = 1'b1;
		if ($urandom_range(0, 9) == 0)
			cyc = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
		else if (mode[vbps_pkg::MODE_CYCLE_VOLUME])
			cyc = 24'($urandom_range(0, 40000));
		else
			cyc = 24'($urandom_range(0, 12));
		pause_len = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 6));
		trig_len = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 10));
		trig_p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600) - 300);
		peep = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
		program_breath(mode, cyc, 16'($urandom), pause_len, trig_len, trig_p, peep);
	endtask

	function automatic vbps_pkg::tick_beat_t mk_tick(input logic c, input logic [15:0] dv,
			input logic [15:0] vp, input logic [15:0] cp, input logic [15:0] ap);
		vbps_pkg::tick_beat_t b;
		b.connected = c;
		b.volume_delta = dv;
		b.ventilator_pressure = vp;
		b.connection_pressure = cp;
		b.ambient_pressure = ap;
		return b;
	endfunction

	// Mostly connected ticks with moderate values; a quarter of each field full range.
	function automatic vbps_pkg::tick_beat_t rand_tick();
		vbps_pkg::tick_beat_t b;
		b.connected = ($urandom_range(0, 15) != 0);
		b.volume_delta = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 6000) - 1000);
		b.ventilator_pressure = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 800) - 400);
		b.connection_pressure = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 800) - 400);
		b.ambient_pressure = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 800) - 400);
		return b;
	endfunction

	// Sends one tick beat after a random gap and notes it once accepted.
	task automatic send_tick(input vbps_pkg::tick_beat_t beat);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_valid <= 1'b1;
		tick <= beat;
		@(posedge clk);
		while (tick_stall) @(posedge clk);
		sb.take_tick(beat);
	endtask

	// Holds the tick channel off until every due result is back, then lets the pipe empty.
	task automatic settle();
		tick_valid <= 1'b0;
		@(posedge clk);
		while (sb.waiting() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	initial begin
		int sent;
		int burst;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: cascading phases and the default zero pressure driver.
		send_tick(mk_tick(1'b1, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF));
		send_tick(mk_tick(1'b1, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000));
		send_tick(mk_tick(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_tick(mk_tick(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		settle();

		// No trigger enabled: exhale holds PEEP and flags the error.
		program_breath(4'b0000, 24'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
		send_tick(mk_tick(1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
		send_tick(mk_tick(1'b1, 16'd5, 16'd5, 16'd5, 16'd5));
		send_tick(mk_tick(1'b1, 16'h7FFF, 16'd0, 16'h8000, 16'h7FFF));
		settle();

		// Volume-cycled flow breath with patient trigger and a two-tick pause.
		program_breath(4'b1011, 24'd100, 16'h7FFF, 16'd2, 16'd0, 16'h8000, 16'h7FFF);
		send_tick(mk_tick(1'b1, 16'd0, 16'd0, 16'h8000, 16'h7FFF));
		send_tick(mk_tick(1'b1, 16'd50, 16'd100, 16'd0, 16'd0));
		send_tick(mk_tick(1'b1, 16'd50, 16'd200, 16'd0, 16'd0));
		send_tick(mk_tick(1'b1, 16'd0, 16'hFED4, 16'd0, 16'd0));
		send_tick(mk_tick(1'b1, 16'd0, 16'd0, 16'h7FFF, 16'h8000));
		settle();

		// Time-cycled flow breath with machine trigger and no pause.
		program_breath(4'b0110, 24'd3, 16'h8000, 16'd0, 16'd2, 16'd0, 16'd0);
		repeat (8) send_tick(mk_tick(1'b1, 16'd300, 16'd40, 16'd20, 16'd0));
		settle();

		// Random phases, each under its own settings and idling style.
		sent = 0;
		while (sent < 830) begin
			program_random();
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			burst = $urandom_range(30, 90);
			repeat (burst) begin
				if (!tx_calm && $urandom_range(0, 39) == 0) settle();
				send_tick(rand_tick());
			end
			sent += burst;
			settle();
		end

		if (sb.fails == 0 && sb.waiting() == 0) begin
			$display("ventilator_breath_phase_sequencer_top verification clean");
		end else begin
			$display("ventilator_breath_phase_sequencer_top verification failed");
		end
		$finish;
	end

endmodule
